### rtl/core/delaunay_flip_predicate_macros.svh
// Assertion macros used by the RTL of the Delaunay flip predicate.
`ifndef DELAUNAY_FLIP_PREDICATE_MACROS_SVH
`define DELAUNAY_FLIP_PREDICATE_MACROS_SVH
`ifndef SYNTHESIS
`define DFP_ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("delaunay_flip_predicate: assertion failed");
`define DFP_ASSERT_HOLD(lbl, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error("delaunay_flip_predicate: held value changed");
`else
`define DFP_ASSERT_CLK(lbl, prop)
`define DFP_ASSERT_HOLD(lbl, cond, sig)
`endif
`endif

### rtl/core/dfp_pkg.sv
// Shared constants and types of the Delaunay flip predicate.
package dfp_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int IN_WIDTH        = 32;

	localparam logic signed [1:0] VERDICT_NEG  = 2'sb11;
	localparam logic signed [1:0] VERDICT_ZERO = 2'sb00;
	localparam logic signed [1:0] VERDICT_POS  = 2'sb01;

	// Stage enables of the split wide multiplier.
	typedef struct packed {
		logic pp;
		logic mid;
		logic fin;
	} mul_en_t;

endpackage

### rtl/core/dfp_wmul.sv
// Three-stage exact signed multiplier built from half-width partial products.
module dfp_wmul #(
	parameter int OP_WIDTH = 67
) (
	input  logic                           clk,
	input  dfp_pkg::mul_en_t               en,
	input  logic signed [OP_WIDTH-1:0]     a,
	input  logic signed [OP_WIDTH-1:0]     b,
	output logic signed [2*OP_WIDTH-1:0]   prod
);

	localparam int K = (OP_WIDTH + 1) / 2;
	localparam int H = OP_WIDTH - K;
	localparam int P = 2 * OP_WIDTH;

	logic        [K-1:0]     a_lo, b_lo;
	logic signed [H-1:0]     a_hi, b_hi;

	logic        [2*K-1:0]   ll_s1;
	logic signed [K+H:0]     lh_s1, hl_s1;
	logic signed [2*H-1:0]   hh_s1;

	logic signed [K+H+1:0]   mid_s2;
	logic signed [P-1:0]     cat_s2;

	logic signed [P-1:0]     mid_ext;
	logic signed [P-1:0]     prod_s3;

	assign a_lo = a[K-1:0];
	assign b_lo = b[K-1:0];
	assign a_hi = a[OP_WIDTH-1:K];
	assign b_hi = b[OP_WIDTH-1:K];

	// The low halves are unsigned, the high halves carry the sign.
	always_ff @(posedge clk) begin
		if (en.pp) begin
			ll_s1 <= a_lo * b_lo;
			lh_s1 <= $signed({1'b0, a_lo}) * b_hi;
			hl_s1 <= a_hi * $signed({1'b0, b_lo});
			hh_s1 <= a_hi * b_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (en.mid) begin
			mid_s2 <= (K+H+2)'(lh_s1) + (K+H+2)'(hl_s1);
			cat_s2 <= {hh_s1, ll_s1};
		end
	end

	assign mid_ext = P'(mid_s2) <<< K;

	always_ff @(posedge clk) begin
		if (en.fin) begin
			prod_s3 <= cat_s2 + mid_ext;
		end
	end

	assign prod = prod_s3;

endmodule

### rtl/core/delaunay_flip_predicate.sv
// Top level of the exact Delaunay edge-flip predicate pipeline.
//
//   channel  signals                              direction
//   in       in_valid, in_ready, p1_x .. p4_y     into the block
//   out      out_valid, out_ready, verdict        out of the block
//
// One item is taken every cycle while the output is not stalled; a result passes
// through the eight register stages in order: differences, coordinate products, sine and
// cosine sums, three stages of the split 67-bit multiply, final add, sign.
// Reset clears only the stage valid bits; the data registers are left as they are.
// A stalled output holds its stage, and empty stages ahead of a stall keep filling,
// so the input stays ready until every stage holds an item.
module delaunay_flip_predicate #(
	parameter int COORD_WIDTH = dfp_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dfp_pkg::IN_WIDTH-1:0]   p1_x,
	input  logic [dfp_pkg::IN_WIDTH-1:0]   p1_y,
	input  logic [dfp_pkg::IN_WIDTH-1:0]   p2_x,
	input  logic [dfp_pkg::IN_WIDTH-1:0]   p2_y,
	input  logic [dfp_pkg::IN_WIDTH-1:0]   p3_x,
	input  logic [dfp_pkg::IN_WIDTH-1:0]   p3_y,
	input  logic [dfp_pkg::IN_WIDTH-1:0]   p4_x,
	input  logic [dfp_pkg::IN_WIDTH-1:0]   p4_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [1:0]              verdict
);

	`include "delaunay_flip_predicate_macros.svh"

	localparam int CW  = COORD_WIDTH;
	localparam int D   = CW + 1;
	localparam int M   = 2 * D;
	localparam int S   = M + 1;
	localparam int P   = 2 * S;
	localparam int T   = P + 1;
	localparam int NST = 8;

	logic [NST-1:0] stage_vld_q;
	logic [NST-1:0] stage_en;

	logic [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

	logic signed [D-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, ex_s1, ey_s1;
	logic signed [M-1:0] axby_s2, bxay_s2, axbx_s2, ayby_s2;
	logic signed [M-1:0] cxey_s2, excy_s2, cxex_s2, cyey_s2;
	logic signed [S-1:0] s123_s3, c123_s3, s341_s3, c341_s3;
	logic signed [P-1:0] prod_a, prod_b;
	logic signed [T-1:0] sum_s7;
	logic signed [1:0]   verdict_s8;

	dfp_pkg::mul_en_t mul_en;

	// A stage moves when it is empty or the stage after it moves.
	always_comb begin
		stage_en[NST-1] = !stage_vld_q[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			stage_en[i] = !stage_vld_q[i] || stage_en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (stage_en[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	assign in_ready  = stage_en[0];
	assign out_valid = stage_vld_q[NST-1];

	assign x1 = p1_x[CW-1:0];
	assign y1 = p1_y[CW-1:0];
	assign x2 = p2_x[CW-1:0];
	assign y2 = p2_y[CW-1:0];
	assign x3 = p3_x[CW-1:0];
	assign y3 = p3_y[CW-1:0];
	assign x4 = p4_x[CW-1:0];
	assign y4 = p4_y[CW-1:0];

	// Differences are exact in one extra bit.
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			ax_s1 <= {1'b0, x3} - {1'b0, x2};
			ay_s1 <= {1'b0, y3} - {1'b0, y2};
			bx_s1 <= {1'b0, x1} - {1'b0, x2};
			by_s1 <= {1'b0, y1} - {1'b0, y2};
			cx_s1 <= {1'b0, x1} - {1'b0, x4};
			cy_s1 <= {1'b0, y1} - {1'b0, y4};
			ex_s1 <= {1'b0, x3} - {1'b0, x4};
			ey_s1 <= {1'b0, y3} - {1'b0, y4};
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			axby_s2 <= ax_s1 * by_s1;
			bxay_s2 <= bx_s1 * ay_s1;
			axbx_s2 <= ax_s1 * bx_s1;
			ayby_s2 <= ay_s1 * by_s1;
			cxey_s2 <= cx_s1 * ey_s1;
			excy_s2 <= ex_s1 * cy_s1;
			cxex_s2 <= cx_s1 * ex_s1;
			cyey_s2 <= cy_s1 * ey_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			s123_s3 <= S'(axby_s2) - S'(bxay_s2);
			c123_s3 <= S'(axbx_s2) + S'(ayby_s2);
			s341_s3 <= S'(cxey_s2) - S'(excy_s2);
			c341_s3 <= S'(cxex_s2) + S'(cyey_s2);
		end
	end

	assign mul_en.pp  = stage_en[3];
	assign mul_en.mid = stage_en[4];
	assign mul_en.fin = stage_en[5];

	dfp_wmul #(
		.OP_WIDTH(S)
	) u_mul_a (
		.clk (clk),
		.en  (mul_en),
		.a   (s123_s3),
		.b   (c341_s3),
		.prod(prod_a)
	);

	dfp_wmul #(
		.OP_WIDTH(S)
	) u_mul_b (
		.clk (clk),
		.en  (mul_en),
		.a   (c123_s3),
		.b   (s341_s3),
		.prod(prod_b)
	);

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			sum_s7 <= T'(prod_a) + T'(prod_b);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			if (sum_s7 == '0) begin
				verdict_s8 <= dfp_pkg::VERDICT_ZERO;
			end else if (sum_s7[T-1]) begin
				verdict_s8 <= dfp_pkg::VERDICT_NEG;
			end else begin
				verdict_s8 <= dfp_pkg::VERDICT_POS;
			end
		end
	end

	assign verdict = verdict_s8;

	`DFP_ASSERT_CLK(a_accept_lands, in_valid && in_ready |=> stage_vld_q[0])
	`DFP_ASSERT_CLK(a_full_when_blocked, !in_ready |-> &stage_vld_q)
	`DFP_ASSERT_HOLD(a_mul_holds, !stage_en[5], prod_a)
	`DFP_ASSERT_CLK(a_out_from_sum, $rose(out_valid) |-> $past(stage_vld_q[6]))

endmodule

### tb/delaunay_flip_predicate_tb.sv
// Self-checking testbench for the Delaunay edge-flip predicate pipeline.
`timescale 1ns / 1ps

module delaunay_flip_predicate_tb;

	localparam int IN_WIDTH = dfp_pkg::IN_WIDTH;
	localparam int COORD_W  = dfp_pkg::COORD_WIDTH_DEF;
	localparam int WW       = 160;
	localparam logic [IN_WIDTH-1:0] CMASK = IN_WIDTH'((64'd1 << COORD_W) - 64'd1);
	localparam logic [IN_WIDTH-1:0] CMAX  = '1;

	// Index 0..3 stands for points p1..p4.
	typedef struct packed {
		logic [3:0][IN_WIDTH-1:0] x;
		logic [3:0][IN_WIDTH-1:0] y;
	} quad_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [IN_WIDTH-1:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y;
	logic out_valid;
	logic out_ready;
	logic signed [1:0] verdict;

	bit in_gaps;
	bit out_stalls;

	class flip_scoreboard;
		logic signed [1:0] verdict_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Exact sign of sin123*cos341 + cos123*sin341 on wide signed vectors.
		function logic signed [1:0] flip_sign(quad_t q);
			logic signed [WW-1:0] px[4];
			logic signed [WW-1:0] py[4];
			logic signed [WW-1:0] ax, ay, bx, by, cx, cy, ex, ey;
			logic signed [WW-1:0] s123, c123, s341, c341, sum;
			for (int i = 0; i < 4; i++) begin
				px[i] = {{(WW - IN_WIDTH){1'b0}}, q.x[i] & CMASK};
				py[i] = {{(WW - IN_WIDTH){1'b0}}, q.y[i] & CMASK};
			end
			ax = px[2] - px[1];
			ay = py[2] - py[1];
			bx = px[0] - px[1];
			by = py[0] - py[1];
			cx = px[0] - px[3];
			cy = py[0] - py[3];
			ex = px[2] - px[3];
			ey = py[2] - py[3];
			s123 = ax * by - bx * ay;
			c123 = ax * bx + ay * by;
			s341 = cx * ey - ex * cy;
			c341 = cx * ex + cy * ey;
			sum  = s123 * c341 + c123 * s341;
			if (sum == 0)
				return dfp_pkg::VERDICT_ZERO;
			else if (sum < 0)
				return dfp_pkg::VERDICT_NEG;
			return dfp_pkg::VERDICT_POS;
		endfunction

		function void note_quad(quad_t q);
			verdict_q.insert(verdict_q.size(), flip_sign(q));
		endfunction

		function void check_verdict(logic signed [1:0] actual);
			logic signed [1:0] exp_v;
			if (verdict_q.size() == 0) begin
				$error("verdict: result %0d with no item outstanding", actual);
				errors++;
				return;
			end
			exp_v = verdict_q.pop_front();
			if (actual !== exp_v) begin
				$error("verdict: expected %0d, actual %0d", exp_v, actual);
				errors++;
			end
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	flip_scoreboard sb = new();

	delaunay_flip_predicate #(
		.COORD_WIDTH(COORD_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.p1_x(p1_x),
		.p1_y(p1_y),
		.p2_x(p2_x),
		.p2_y(p2_y),
		.p3_x(p3_x),
		.p3_y(p3_y),
		.p4_x(p4_x),
		.p4_y(p4_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		quad_t q;
		if (arst_n && in_valid && in_ready) begin
			q.x = {p4_x, p3_x, p2_x, p1_x};
			q.y = {p4_y, p3_y, p2_y, p1_y};
			sb.note_quad(q);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_verdict(verdict);
	end

	function automatic quad_t mk_quad(logic [IN_WIDTH-1:0] x1, logic [IN_WIDTH-1:0] y1,
			logic [IN_WIDTH-1:0] x2, logic [IN_WIDTH-1:0] y2,
			logic [IN_WIDTH-1:0] x3, logic [IN_WIDTH-1:0] y3,
			logic [IN_WIDTH-1:0] x4, logic [IN_WIDTH-1:0] y4);
		quad_t q;
		q.x = {x4, x3, x2, x1};
		q.y = {y4, y3, y2, y1};
		return q;
	endfunction

	function automatic logic [IN_WIDTH-1:0] edge_coord();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 1;
			2: return CMAX;
			3: return CMAX - 1;
			4: return {1'b1, {(IN_WIDTH - 1){1'b0}}};
			default: return $urandom;
		endcase
	endfunction

	// Four corners of a rectangle lie on one circle; nudging a corner tips the
	// sign either way, which is where a truncated datapath goes wrong.
	function automatic quad_t rect_quad();
		quad_t q;
		logic [IN_WIDTH-1:0] xs[2];
		logic [IN_WIDTH-1:0] ys[2];
		int rot;
		int k;
		bit rev;
		xs[0] = $urandom;
		xs[1] = $urandom_range(0, 1) ? $urandom : xs[0] + $urandom_range(1, 64);
		ys[0] = $urandom;
		ys[1] = $urandom_range(0, 1) ? $urandom : ys[0] + $urandom_range(1, 64);
		rot = $urandom_range(0, 3);
		rev = $urandom_range(0, 1);
		for (int i = 0; i < 4; i++) begin
			k = rev ? (rot + 4 - i) % 4 : (rot + i) % 4;
			q.x[i] = xs[(k == 1 || k == 2) ? 1 : 0];
			q.y[i] = ys[(k >= 2) ? 1 : 0];
		end
		if ($urandom_range(0, 2) != 0) begin
			k = $urandom_range(0, 3);
			if ($urandom_range(0, 1))
				q.x[k] = q.x[k] + IN_WIDTH'($urandom_range(0, 2)) - 1;
			else
				q.y[k] = q.y[k] + IN_WIDTH'($urandom_range(0, 2)) - 1;
		end
		return q;
	endfunction

	function automatic quad_t random_quad();
		quad_t q;
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++) begin
			case (mode)
				4, 5: begin
					q.x[i] = $urandom;
					q.y[i] = $urandom;
				end
				6: begin
					q.x[i] = $urandom_range(0, 7);
					q.y[i] = $urandom_range(0, 7);
				end
				7: begin
					q.x[i] = edge_coord();
					q.y[i] = edge_coord();
				end
				default: begin
					q.x[i] = '0;
					q.y[i] = '0;
				end
			endcase
		end
		if (mode < 4 || mode > 7)
			q = rect_quad();
		return q;
	endfunction

	task automatic send_quad(input quad_t q);
		p1_x <= q.x[0];
		p1_y <= q.y[0];
		p2_x <= q.x[1];
		p2_y <= q.y[1];
		p3_x <= q.x[2];
		p3_y <= q.y[2];
		p4_x <= q.x[3];
		p4_y <= q.y[3];
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		if (in_valid)
			in_valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	task automatic send_with_gap(input quad_t q);
		send_quad(q);
		if (in_gaps && $urandom_range(0, 3) == 0)
			hold_off($urandom_range(1, 17));
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
			if (out_stalls) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17))
					@(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		p1_x = '0;
		p1_y = '0;
		p2_x = '0;
		p2_y = '0;
		p3_x = '0;
		p3_y = '0;
		p4_x = '0;
		p4_y = '0;
		in_gaps    = 1'b1;
		out_stalls = 1'b1;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Coincident, collinear, cocircular and extreme-range quadrilaterals.
		send_with_gap(mk_quad('0, '0, '0, '0, '0, '0, '0, '0));
		send_with_gap(mk_quad(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		send_with_gap(mk_quad('0, '0, CMAX, '0, CMAX, CMAX, '0, CMAX));
		send_with_gap(mk_quad('0, '0, '0, CMAX, CMAX, CMAX, CMAX, '0));
		send_with_gap(mk_quad('0, '0, CMAX, '0, CMAX, CMAX, 1, CMAX - 1));
		send_with_gap(mk_quad('0, '0, CMAX, '0, CMAX, CMAX, '0, CMAX - 1));
		send_with_gap(mk_quad('0, '0, CMAX - 1, 1, CMAX, CMAX, '0, CMAX));
		send_with_gap(mk_quad(CMAX, '0, '0, '0, '0, CMAX, CMAX, CMAX));
		send_with_gap(mk_quad('0, '0, CMAX, '0, '0, CMAX, CMAX, CMAX));
		send_with_gap(mk_quad('0, CMAX, CMAX, '0, '0, '0, CMAX, CMAX));
		send_with_gap(mk_quad('0, '0, 1, 1, 2, 2, 3, 3));
		send_with_gap(mk_quad('0, '0, 5, '0, 9, '0, CMAX, '0));
		send_with_gap(mk_quad(7, 3, 7, 3, 9, 4, 1, 8));
		send_with_gap(mk_quad(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
			32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'h55555555));
		send_with_gap(mk_quad(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
			32'h55555555, 32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA));
		send_with_gap(mk_quad(CMAX, '0, CMAX, CMAX, '0, CMAX, '0, '0));
		send_with_gap(mk_quad(1, 1, CMAX, 1, CMAX, CMAX, 1, CMAX));
		send_with_gap(mk_quad(32'h80000000, '0, CMAX, 32'h80000000, 32'h80000000, CMAX,
			'0, 32'h80000000));
		send_with_gap(mk_quad(32'h80000000, '0, CMAX, 32'h80000000, 32'h80000001, CMAX,
			'0, 32'h80000000));

		for (int n = 0; n < 1000; n++) begin
			if (n % 100 == 0) begin
				in_gaps    = (n < 850) && ($urandom_range(0, 3) != 0);
				out_stalls = (n < 850) && ($urandom_range(0, 3) != 0);
			end
			if (n == 500) begin
				// Let the pipeline drain completely before streaming again.
				hold_off(1);
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_with_gap(random_quad());
		end
		hold_off(1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
